// ----- sv/slkg_pkg.sv -----
// Shared types and constants for the status LED and key gesture controller.
// No dependencies; imported by every module of the block.
package slkg_pkg;

	localparam int unsigned PROFILE_COUNT_DEF = 16;

	localparam logic [9:0]  ACK_MS          = 10'd500;
	localparam logic [13:0] INFO_HOLD_MS    = 14'd10000;
	localparam logic [6:0]  POLL_MS         = 7'd100;
	localparam logic [9:0]  PHASE_WRAP      = 10'd999;
	localparam logic [9:0]  PHASE_HALF      = 10'd500;
	localparam logic [9:0]  PHASE_Q1        = 10'd250;
	localparam logic [9:0]  PHASE_Q3        = 10'd750;

	localparam logic [15:0] LINK_WINDOW_RST = 16'd0;
	localparam logic [15:0] HOLD_LIMIT_RST  = 16'd6000;
	localparam logic [15:0] TAP_TERM_RST    = 16'd300;
	localparam logic [9:0]  REFRESH_RST     = 10'd150;
	localparam logic [7:0]  WATCHED_RST     = 8'd5;
	localparam logic        GUARD_RST       = 1'b1;
	localparam logic [5:0]  FLASH_RST       = 6'd2;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_PRESS   = 3'd1,
		OP_RELEASE = 3'd2,
		OP_PROFILE = 3'd3,
		OP_LAYER   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_LINK_WINDOW = 3'd0,
		REG_HOLD_LIMIT  = 3'd1,
		REG_TAP_TERM    = 3'd2,
		REG_REFRESH     = 3'd3,
		REG_WATCHED     = 3'd4,
		REG_GUARD       = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] link_window_ms;
		logic [15:0] hold_limit_ms;
		logic [15:0] tap_term_ms;
		logic [9:0]  refresh_period_ms;
		logic [7:0]  watched_position;
		logic        guard_enable;
	} cfg_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] key_position;
		logic [3:0] profile_index;
		logic       link_up;
		logic       wired_selected;
		logic       fn_layer_on;
	} item_t;

	typedef struct packed {
		logic led_link_on;
		logic led_info_on;
		logic led_fn_on;
		logic led_warn_on;
		logic led_aux_on;
		logic clear_bonds_pulse;
		logic next_profile_pulse;
		logic toggle_transport_pulse;
	} result_t;

	typedef struct packed {
		logic [9:0]  ms_phase;
		logic [9:0]  refresh_left;
		logic [6:0]  poll_left;
		logic        key_down;
		logic        bond_done;
		logic [15:0] hold_elapsed;
		logic [9:0]  ack_left;
		logic [1:0]  tap_count;
		logic [15:0] tap_wait_left;
		logic        link_prev;
		logic [15:0] link_window_left;
		logic [13:0] info_hold_left;
		logic [5:0]  flash_toggles_left;
		logic        flash_on;
	} state_t;

endpackage

// ----- sv/status_led_and_key_gesture_ctrl.sv -----
// Status LED and key gesture controller, top level.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while out_stall is low; out_stall holds the result,
// one more request is taken into the input register meanwhile, then in_stall rises.
// Reset (arst_n, async, active low): config registers to defaults, controller state to
// its reset values, both pipeline stages empty. Depends on slkg_pkg, slkg_cfg, slkg_core.
module status_led_and_key_gesture_ctrl import slkg_pkg::*; #(
	parameter int unsigned PROFILE_COUNT = PROFILE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  key_position,
	input  logic [3:0]  profile_index,
	input  logic        link_up,
	input  logic        wired_selected,
	input  logic        fn_layer_on,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        led_link_on,
	output logic        led_info_on,
	output logic        led_fn_on,
	output logic        led_warn_on,
	output logic        led_aux_on,
	output logic        clear_bonds_pulse,
	output logic        next_profile_pulse,
	output logic        toggle_transport_pulse
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    out_free;
	logic    adv;
	logic    accept;

	// the result register frees when empty or being taken this edge
	assign out_free = !valid_s2 || !out_stall;
	// the stage-1 request is processed (state committed) as it moves to stage 2
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	slkg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	slkg_core #(
		.PROFILE_COUNT (PROFILE_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op             <= op;
			item_s1.key_position   <= key_position;
			item_s1.profile_index  <= profile_index;
			item_s1.link_up        <= link_up;
			item_s1.wired_selected <= wired_selected;
			item_s1.fn_layer_on    <= fn_layer_on;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign out_valid              = valid_s2;
	assign led_link_on            = res_s2.led_link_on;
	assign led_info_on            = res_s2.led_info_on;
	assign led_fn_on              = res_s2.led_fn_on;
	assign led_warn_on            = res_s2.led_warn_on;
	assign led_aux_on             = res_s2.led_aux_on;
	assign clear_bonds_pulse      = res_s2.clear_bonds_pulse;
	assign next_profile_pulse     = res_s2.next_profile_pulse;
	assign toggle_transport_pulse = res_s2.toggle_transport_pulse;

endmodule

// ----- sv/slkg_cfg.sv -----
// Configuration register file: six registers written through a plain write port.
// Depends on slkg_pkg for cfg_t, register indexes and reset values.
module slkg_cfg import slkg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [2:0]  index,
	input  logic [15:0] data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_window_ms    <= LINK_WINDOW_RST;
			cfg_q.hold_limit_ms     <= HOLD_LIMIT_RST;
			cfg_q.tap_term_ms       <= TAP_TERM_RST;
			cfg_q.refresh_period_ms <= REFRESH_RST;
			cfg_q.watched_position  <= WATCHED_RST;
			cfg_q.guard_enable      <= GUARD_RST;
		end else if (we) begin
			case (reg_idx_t'(index))
				REG_LINK_WINDOW: cfg_q.link_window_ms    <= data;
				REG_HOLD_LIMIT:  cfg_q.hold_limit_ms     <= data;
				REG_TAP_TERM:    cfg_q.tap_term_ms       <= data;
				REG_REFRESH:     cfg_q.refresh_period_ms <= data[9:0];
				REG_WATCHED:     cfg_q.watched_position  <= data[7:0];
				REG_GUARD:       cfg_q.guard_enable      <= data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/slkg_core.sv -----
// Controller state and its single-pass update for one request.
// Depends on slkg_pkg for state, item, config and result types.
module slkg_core import slkg_pkg::*; #(
	parameter int unsigned PROFILE_COUNT = PROFILE_COUNT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	localparam logic [5:0] PROF_MAX = 6'(PROFILE_COUNT - 1);

	state_t st_q;
	state_t nx;

	always_comb begin
		logic        do_ref;
		logic        guarded;
		logic [9:0]  period;
		logic [5:0]  prof;
		op_t         op;

		nx      = st_q;
		do_ref  = 1'b0;
		res     = '0;
		op      = op_t'(item.op);
		guarded = cfg.guard_enable && (item.key_position == cfg.watched_position);
		period  = (cfg.refresh_period_ms == 10'd0) ? 10'd1 : cfg.refresh_period_ms;
		prof    = {2'b00, item.profile_index};
		if (prof >= 6'(PROFILE_COUNT))
			prof = PROF_MAX;

		case (op)
			OP_TICK: begin
				nx.ms_phase = (st_q.ms_phase == PHASE_WRAP) ? 10'd0 : st_q.ms_phase + 10'd1;
				if (st_q.ack_left != 10'd0)
					nx.ack_left = st_q.ack_left - 10'd1;
				if (st_q.link_window_left != 16'd0)
					nx.link_window_left = st_q.link_window_left - 16'd1;
				if (st_q.info_hold_left != 14'd0)
					nx.info_hold_left = st_q.info_hold_left - 14'd1;
				if (st_q.tap_wait_left != 16'd0) begin
					nx.tap_wait_left = st_q.tap_wait_left - 16'd1;
					if (st_q.tap_wait_left == 16'd1) begin
						res.next_profile_pulse = (st_q.tap_count == 2'd1);
						nx.tap_count = 2'd0;
					end
				end
				if (st_q.key_down) begin
					if (st_q.hold_elapsed != 16'hFFFF)
						nx.hold_elapsed = st_q.hold_elapsed + 16'd1;
					if (nx.hold_elapsed >= cfg.hold_limit_ms && !st_q.bond_done) begin
						res.clear_bonds_pulse = 1'b1;
						nx.bond_done          = 1'b1;
						nx.info_hold_left     = INFO_HOLD_MS;
						do_ref                = 1'b1;
					end
					if (st_q.poll_left <= 7'd1) begin
						nx.poll_left = POLL_MS;
						do_ref       = 1'b1;
					end else begin
						nx.poll_left = st_q.poll_left - 7'd1;
					end
				end
				if (st_q.refresh_left <= 10'd1) begin
					nx.refresh_left = 10'd0;
					do_ref          = 1'b1;
				end else begin
					nx.refresh_left = st_q.refresh_left - 10'd1;
				end
			end
			OP_PRESS: begin
				if (guarded) begin
					nx.tap_wait_left = 16'd0;
					nx.key_down      = 1'b1;
					nx.bond_done     = 1'b0;
					nx.hold_elapsed  = 16'd0;
					if (cfg.hold_limit_ms == 16'd0) begin
						res.clear_bonds_pulse = 1'b1;
						nx.bond_done          = 1'b1;
						nx.info_hold_left     = INFO_HOLD_MS;
					end
					nx.poll_left = POLL_MS;
					do_ref       = 1'b1;
				end
			end
			OP_RELEASE: begin
				if (guarded && st_q.key_down) begin
					nx.key_down  = 1'b0;
					nx.poll_left = 7'd0;
					if (st_q.bond_done) begin
						nx.ack_left  = ACK_MS;
						nx.bond_done = 1'b0;
						nx.tap_count = 2'd0;
					end else if (st_q.hold_elapsed <= cfg.tap_term_ms) begin
						if ((st_q.tap_count + 2'd1) >= 2'd2) begin
							nx.tap_count               = 2'd0;
							nx.tap_wait_left           = 16'd0;
							res.toggle_transport_pulse = 1'b1;
						end else begin
							nx.tap_count     = st_q.tap_count + 2'd1;
							nx.tap_wait_left = (cfg.tap_term_ms == 16'd0) ? 16'd1
								: cfg.tap_term_ms;
						end
					end else begin
						nx.tap_count = 2'd0;
					end
					do_ref = 1'b1;
				end
			end
			OP_PROFILE: begin
				nx.info_hold_left     = 14'd0;
				nx.flash_toggles_left = 6'((prof + 6'd1) << 1);
				nx.flash_on           = 1'b0;
				do_ref                = 1'b1;
			end
			OP_LAYER: do_ref = 1'b1;
			default: ;
		endcase

		// refresh step of the info flash
		if (do_ref) begin
			if (nx.flash_toggles_left != 6'd0) begin
				nx.flash_on           = !nx.flash_on;
				nx.flash_toggles_left = nx.flash_toggles_left - 6'd1;
			end else begin
				nx.flash_on = 1'b0;
			end
			nx.refresh_left = period;
		end

		if (item.link_up && !st_q.link_prev)
			nx.link_window_left = cfg.link_window_ms;
		nx.link_prev = item.link_up;

		if (item.wired_selected)
			res.led_link_on = 1'b0;
		else if (!item.link_up)
			res.led_link_on = (nx.ms_phase >= PHASE_HALF);
		else if (cfg.link_window_ms == 16'd0)
			res.led_link_on = 1'b1;
		else
			res.led_link_on = (nx.link_window_left != 16'd0);

		res.led_info_on = nx.flash_on || (nx.info_hold_left != 14'd0);
		if (nx.key_down)
			res.led_warn_on = nx.bond_done
				|| (nx.ms_phase >= PHASE_Q1 && nx.ms_phase < PHASE_HALF)
				|| (nx.ms_phase >= PHASE_Q3);
		else
			res.led_warn_on = (nx.ack_left != 10'd0);
		res.led_fn_on  = item.fn_layer_on;
		res.led_aux_on = item.wired_selected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.ms_phase           <= '0;
			st_q.refresh_left       <= REFRESH_RST;
			st_q.poll_left          <= '0;
			st_q.key_down           <= 1'b0;
			st_q.bond_done          <= 1'b0;
			st_q.hold_elapsed       <= '0;
			st_q.ack_left           <= '0;
			st_q.tap_count          <= '0;
			st_q.tap_wait_left      <= '0;
			st_q.link_prev          <= 1'b0;
			st_q.link_window_left   <= '0;
			st_q.info_hold_left     <= '0;
			st_q.flash_toggles_left <= FLASH_RST;
			st_q.flash_on           <= 1'b0;
		end else if (adv) begin
			st_q <= nx;
		end
	end

endmodule
